### design/bblru_pkg.sv
// shared types and constants for the byte budget lru cache
package bblru_pkg;

    localparam int SLOTS_DEFAULT = 32;
    localparam int KEY_W         = 40;
    localparam int LEN_W         = 32;
    localparam int SLOT_W        = 5;
    localparam logic [LEN_W-1:0] BUDGET_RESET = LEN_W'(1024 * 1024 * 256);

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_EVICT  = 2'd2
    } kind_t;

    typedef enum logic {
        MODE_LOOKUP = 1'b0,
        MODE_INSERT = 1'b1
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic refuse;
        logic evict;
        logic store;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_insert;
        logic too_long;
        logic need_evict;
        logic out_stall;
    } dp_status_t;

endpackage

### design/bblru_req_if.sv
// request channel carrying one lookup or insert word
interface bblru_req_if
    import bblru_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] length;

    modport source (output valid, output mode, output key, output length, input ready);
    modport sink (input valid, input mode, input key, input length, output ready);
endinterface

### design/bblru_rsp_if.sv
// response channel carrying one answer or eviction word
interface bblru_rsp_if
    import bblru_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  evicted_key;
    logic [LEN_W-1:0]  evicted_length;
    logic [LEN_W-1:0]  used_bytes_now;
    logic              last;

    modport source (output valid, output kind, output hit, output slot, output evicted_key,
                    output evicted_length, output used_bytes_now, output last, input ready);
    modport sink (input valid, input kind, input hit, input slot, input evicted_key,
                  input evicted_length, input used_bytes_now, input last, output ready);
endinterface

### design/byte_budget_lru_cache.sv
// byte budget lru cache tracker, top level
// requests are taken only in the idle state into the input registers; each result word is
// registered by the single step datapath; lookups and refused inserts give one word, an
//   insert E evictions, one per cycle unless stalled, then its store word
// a stalled response register holds the step sequencer until the word is taken
// reset clears valid bits, age ranks, byte usage and entry count, budget goes to 256 MiB
module byte_budget_lru_cache
    import bblru_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    bblru_req_if.sink        req,
    bblru_rsp_if.source      rsp
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       ready;

    assign req.ready = ready;

    bblru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .status    (status),
        .cmd       (cmd)
    );

    bblru_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_mode   (req.mode),
        .req_key    (req.key),
        .req_length (req.length),
        .cmd        (cmd),
        .status     (status),
        .rsp        (rsp)
    );

endmodule

### design/bblru_ctrl.sv
// controller state machine sequencing lookup, refusal, eviction and store steps
module bblru_ctrl
    import bblru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   fire;

    assign fire = !status.out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (fire && !(status.is_insert && !status.too_long && status.need_evict))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_STEP:
            begin
                cmd.lookup = fire && !status.is_insert;
                cmd.refuse = fire && status.is_insert && status.too_long;
                cmd.evict  = fire && status.is_insert && !status.too_long && status.need_evict;
                cmd.store  = fire && status.is_insert && !status.too_long && !status.need_evict;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

### design/bblru_dp.sv
// datapath: slot table, age ranks, byte usage and the output register
module bblru_dp
    import bblru_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    input  logic             req_mode,
    input  logic [KEY_W-1:0] req_key,
    input  logic [LEN_W-1:0] req_length,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    bblru_rsp_if.source      rsp
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [KEY_W-1:0] key_reg [SLOTS];
    logic [LEN_W-1:0] len_reg [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic [IDX_W-1:0] rank_reg  [SLOTS];
    logic [IDX_W-1:0] rank_next [SLOTS];
    logic [LEN_W-1:0] used_reg;
    logic [LEN_W-1:0] used_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [LEN_W-1:0] budget_reg;

    logic             mode_reg;
    logic [KEY_W-1:0] in_key_reg;
    logic [LEN_W-1:0] in_len_reg;

    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic              out_hit_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [KEY_W-1:0]  out_ekey_reg;
    logic [LEN_W-1:0]  out_elen_reg;
    logic [LEN_W-1:0]  out_used_reg;
    logic              out_last_reg;

    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;
    logic             old_found;
    logic [IDX_W-1:0] old_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] sel_idx;
    logic [IDX_W-1:0] sel_rank;
    logic [LEN_W-1:0] avail;
    logic [LEN_W-1:0] old_len;
    logic             load;

    // lowest matching, oldest and free slots
    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        old_found  = 1'b0;
        old_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == in_key_reg)
            begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
            if (valid_reg[i] && rank_reg[i] == '0)
            begin
                old_found = 1'b1;
                old_idx   = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign avail    = (budget_reg >= used_reg) ? (budget_reg - used_reg) : '0;
    assign sel_idx  = cmd.evict ? old_idx : hit_idx;
    assign sel_rank = rank_reg[sel_idx];
    assign old_len  = len_reg[old_idx];

    assign status.is_insert  = (mode_reg == MODE_INSERT);
    assign status.too_long   = (in_len_reg > budget_reg);
    assign status.need_evict = (count_reg != '0) && old_found
                               && !((avail >= in_len_reg) && (count_reg < CNT_W'(SLOTS)));
    assign status.out_stall  = out_valid_reg && !rsp.ready;

    assign load = cmd.lookup || cmd.refuse || cmd.evict || cmd.store;

    // age order, valid bits, usage and count
    always_comb
    begin
        valid_next = valid_reg;
        used_next  = used_reg;
        count_next = count_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            rank_next[i] = rank_reg[i];
            if ((cmd.lookup && hit_found) || cmd.evict)
            begin
                if (IDX_W'(i) == sel_idx)
                begin
                    rank_next[i] = cmd.evict ? '0 : IDX_W'(count_reg - 1'b1);
                end
                else if (valid_reg[i] && rank_reg[i] > sel_rank)
                begin
                    rank_next[i] = rank_reg[i] - 1'b1;
                end
            end
            if (cmd.store && free_found && IDX_W'(i) == free_idx)
            begin
                rank_next[i] = IDX_W'(count_reg);
            end
        end
        if (cmd.evict)
        begin
            valid_next[old_idx] = 1'b0;
            count_next          = count_reg - 1'b1;
            used_next           = (used_reg >= old_len) ? (used_reg - old_len) : '0;
        end
        if (cmd.store && free_found)
        begin
            valid_next[free_idx] = 1'b1;
            count_next           = count_reg + 1'b1;
            used_next            = used_reg + in_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            used_reg      <= '0;
            count_reg     <= '0;
            budget_reg    <= BUDGET_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
            if (cfg_we)
            begin
                budget_reg <= cfg_wdata;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // slot payload and captured request
    always_ff @(posedge clk)
    begin
        if (cmd.store && free_found)
        begin
            key_reg[free_idx] <= in_key_reg;
            len_reg[free_idx] <= in_len_reg;
        end
        if (cmd.capture)
        begin
            mode_reg   <= req_mode;
            in_key_reg <= req_key;
            in_len_reg <= req_length;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_ekey_reg <= '0;
            out_elen_reg <= '0;
            out_used_reg <= used_next;
            out_last_reg <= !cmd.evict;
            out_hit_reg  <= 1'b0;
            out_slot_reg <= '0;
            out_kind_reg <= KIND_INSERT;
            if (cmd.lookup)
            begin
                out_kind_reg <= KIND_LOOKUP;
                out_hit_reg  <= hit_found;
                out_slot_reg <= hit_found ? SLOT_W'(hit_idx) : '0;
            end
            else if (cmd.evict)
            begin
                out_kind_reg <= KIND_EVICT;
                out_slot_reg <= SLOT_W'(old_idx);
                out_ekey_reg <= key_reg[old_idx];
                out_elen_reg <= old_len;
            end
            else if (cmd.store)
            begin
                out_hit_reg  <= free_found;
                out_slot_reg <= free_found ? SLOT_W'(free_idx) : '0;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.kind           = out_kind_reg;
    assign rsp.hit            = out_hit_reg;
    assign rsp.slot           = out_slot_reg;
    assign rsp.evicted_key    = out_ekey_reg;
    assign rsp.evicted_length = out_elen_reg;
    assign rsp.used_bytes_now = out_used_reg;
    assign rsp.last           = out_last_reg;

endmodule

### bench/tb_top.sv
// testbench for byte_budget_lru_cache: directed table, then random lookup and insert traffic
module tb_top;
    import bblru_pkg::*;

    localparam int NSLOT = SLOTS_DEFAULT;
    localparam int RANDOM_ITEMS = 290;
    localparam int QUIET_ITEMS = 40;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef struct packed {
        kind_t             kind;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  ekey;
        logic [LEN_W-1:0]  elen;
        logic [LEN_W-1:0]  used;
        logic              last;
    } cache_word_t;

    typedef struct {
        bit               set_budget;
        logic [LEN_W-1:0] budget;
        mode_t            mode;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] length;
        bit               typed;
        cache_word_t      want;
    } access_row_t;

    typedef enum int {
        PH_FILL,
        PH_TIGHT,
        PH_WIDE,
        PH_SHRINK,
        PH_KEEP
    } phase_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    bblru_req_if req_ch();
    bblru_rsp_if rsp_ch();

    byte_budget_lru_cache dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // mirror of the cache contents
    logic [KEY_W-1:0] held_key [NSLOT];
    logic [LEN_W-1:0] held_len [NSLOT];
    bit               held_live [NSLOT];
    int               held_age [NSLOT];
    logic [LEN_W-1:0] bytes_held;
    logic [LEN_W-1:0] budget_now;
    int               entries_held;

    cache_word_t      words_due[$];
    logic [KEY_W-1:0] recent_keys[$];
    cache_word_t      seen_word;
    cache_word_t      due_word;

    bit          quiet;
    int unsigned cycle_count;
    int          word_errors;
    int          words_seen;
    int          lookups_sent;
    int          inserts_sent;
    int          evictions_seen;
    int          hits_seen;
    int          refusals_seen;
    int          full_table_inserts;
    int          budget_writes;

    always #6 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    function automatic cache_word_t answer(kind_t kind, logic hit, int slot,
                                           logic [LEN_W-1:0] used);
        cache_word_t w;
        w = '0;
        w.kind = kind;
        w.hit = hit;
        w.slot = SLOT_W'(slot);
        w.used = used;
        w.last = 1'b1;
        return w;
    endfunction

    function automatic string show(cache_word_t w);
        return $sformatf("kind %0d hit %0d slot %0d key %h len %h used %h last %0d",
                         w.kind, w.hit, w.slot, w.ekey, w.elen, w.used, w.last);
    endfunction

    // younger entries each move one step older
    function automatic void age_out(int s);
        int i;
        for (i = 0; i < NSLOT; i++)
            if (held_live[i] && i != s && held_age[i] > held_age[s])
                held_age[i]--;
    endfunction

    function automatic void track_access(mode_t mode, logic [KEY_W-1:0] key,
                                         logic [LEN_W-1:0] length);
        int               i;
        int               pick;
        logic [LEN_W-1:0] room;
        cache_word_t      w;
        pick = -1;
        if (mode == MODE_LOOKUP)
        begin
            for (i = 0; i < NSLOT; i++)
                if (pick < 0 && held_live[i] && held_key[i] == key)
                    pick = i;
            if (pick < 0)
                words_due.push_back(answer(KIND_LOOKUP, 1'b0, 0, bytes_held));
            else
            begin
                age_out(pick);
                held_age[pick] = entries_held - 1;
                words_due.push_back(answer(KIND_LOOKUP, 1'b1, pick, bytes_held));
            end
            return;
        end
        if (length > budget_now)
        begin
            words_due.push_back(answer(KIND_INSERT, 1'b0, 0, bytes_held));
            return;
        end
        if (entries_held == NSLOT)
            full_table_inserts++;
        while (1)
        begin
            room = (budget_now >= bytes_held) ? budget_now - bytes_held : '0;
            if (entries_held == 0 || (room >= length && entries_held < NSLOT))
                break;
            pick = -1;
            for (i = 0; i < NSLOT; i++)
                if (pick < 0 && held_live[i] && held_age[i] == 0)
                    pick = i;
            if (pick < 0)
                break;
            age_out(pick);
            held_live[pick] = 1'b0;
            held_age[pick] = 0;
            entries_held--;
            bytes_held = (bytes_held >= held_len[pick]) ? bytes_held - held_len[pick] : '0;
            w = answer(KIND_EVICT, 1'b0, pick, bytes_held);
            w.ekey = held_key[pick];
            w.elen = held_len[pick];
            w.last = 1'b0;
            words_due.push_back(w);
        end
        pick = -1;
        for (i = 0; i < NSLOT; i++)
            if (pick < 0 && !held_live[i])
                pick = i;
        if (pick < 0)
            words_due.push_back(answer(KIND_INSERT, 1'b0, 0, bytes_held));
        else
        begin
            held_live[pick] = 1'b1;
            held_key[pick] = key;
            held_len[pick] = length;
            held_age[pick] = entries_held;
            entries_held++;
            bytes_held = bytes_held + length;
            words_due.push_back(answer(KIND_INSERT, 1'b1, pick, bytes_held));
        end
    endfunction

    function automatic access_row_t plan_row(bit set_budget, logic [LEN_W-1:0] budget,
                                             mode_t mode, logic [KEY_W-1:0] key,
                                             logic [LEN_W-1:0] length, bit typed,
                                             cache_word_t want);
        access_row_t r;
        r.set_budget = set_budget;
        r.budget = budget;
        r.mode = mode;
        r.key = key;
        r.length = length;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        return {8'($urandom_range(0, 255)), 32'($urandom)};
    endfunction

    function automatic logic [LEN_W-1:0] pick_length(phase_t ph);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        case (ph)
            PH_FILL: return LEN_W'($urandom_range(0, 4096));
            PH_WIDE:
            begin
                if (roll == 0)
                    return LEN_W'($urandom);
                return LEN_W'($urandom) % (budget_now / 3 + 1);
            end
            default:
            begin
                if (roll == 0)
                    return budget_now;
                if (roll == 1)
                    return budget_now + 1;
                if (roll == 2)
                    return '0;
                return LEN_W'($urandom_range(0, budget_now / 2));
            end
        endcase
    endfunction

    task automatic send_access(mode_t mode, logic [KEY_W-1:0] key, logic [LEN_W-1:0] length);
        req_ch.valid  <= 1'b1;
        req_ch.mode   <= mode;
        req_ch.key    <= key;
        req_ch.length <= length;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        track_access(mode, key, length);
        if (mode == MODE_INSERT)
            inserts_sent++;
        else
            lookups_sent++;
    endtask

    task automatic maybe_pause();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14))
                @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_budget(logic [LEN_W-1:0] value);
        wait_drained();
        repeat (3)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        budget_now = value;
        budget_writes++;
    endtask

    // response side stalls
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 11) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14))
                    @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen_word.kind = kind_t'(rsp_ch.kind);
            seen_word.hit = rsp_ch.hit;
            seen_word.slot = rsp_ch.slot;
            seen_word.ekey = rsp_ch.evicted_key;
            seen_word.elen = rsp_ch.evicted_length;
            seen_word.used = rsp_ch.used_bytes_now;
            seen_word.last = rsp_ch.last;
            words_seen++;
            if (seen_word.kind == KIND_EVICT)
                evictions_seen++;
            if (seen_word.kind == KIND_LOOKUP && seen_word.hit)
                hits_seen++;
            if (seen_word.kind == KIND_INSERT && !seen_word.hit)
                refusals_seen++;
            if (words_due.size() == 0)
            begin
                if (word_errors < 10)
                    $display("unexpected word: %s", show(seen_word));
                word_errors++;
            end
            else
            begin
                due_word = words_due.pop_front();
                if (seen_word !== due_word)
                begin
                    if (word_errors < 10)
                    begin
                        $display("word mismatch at cycle %0d", cycle_count);
                        $display("  want %s", show(due_word));
                        $display("  got  %s", show(seen_word));
                    end
                    word_errors++;
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d words still due", cycle_count, words_due.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        access_row_t      plan[$];
        access_row_t      row;
        phase_t           ph;
        mode_t            mode;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] length;
        int               items_random;
        int               phases_run;
        int               burst;
        int               insert_pct;
        int               n;
        int               i;

        for (i = 0; i < NSLOT; i++)
        begin
            held_key[i] = '0;
            held_len[i] = '0;
            held_live[i] = 1'b0;
            held_age[i] = 0;
        end
        bytes_held = '0;
        entries_held = 0;
        budget_now = BUDGET_RESET;
        quiet = 1'b0;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        req_ch.valid  <= 1'b0;
        req_ch.mode   <= MODE_LOOKUP;
        req_ch.key    <= '0;
        req_ch.length <= '0;

        // empty cache, reset budget
        plan.push_back(plan_row(0, '0, MODE_LOOKUP, '0, '0, 1,
                                answer(KIND_LOOKUP, 1'b0, 0, '0)));
        plan.push_back(plan_row(0, '0, MODE_LOOKUP, KEY_MAX, '0, 1,
                                answer(KIND_LOOKUP, 1'b0, 0, '0)));
        plan.push_back(plan_row(0, '0, MODE_INSERT, '0, LEN_MAX, 1,
                                answer(KIND_INSERT, 1'b0, 0, '0)));
        plan.push_back(plan_row(0, '0, MODE_INSERT, KEY_MAX, BUDGET_RESET, 1,
                                answer(KIND_INSERT, 1'b1, 0, BUDGET_RESET)));
        plan.push_back(plan_row(0, '0, MODE_INSERT, 40'h01_2345_6789, 32'd1, 0, '0));
        plan.push_back(plan_row(0, '0, MODE_LOOKUP, 40'h01_2345_6789, '0, 0, '0));
        plan.push_back(plan_row(0, '0, MODE_INSERT, 40'd5, 32'd0, 0, '0));
        // same key twice, lookup answers from the lower slot
        plan.push_back(plan_row(0, '0, MODE_INSERT, 40'd5, 32'd7, 0, '0));
        plan.push_back(plan_row(0, '0, MODE_LOOKUP, 40'd5, '0, 0, '0));
        plan.push_back(plan_row(0, '0, MODE_LOOKUP, 40'h01_2345_6789, '0, 0, '0));
        plan.push_back(plan_row(0, '0, MODE_INSERT, 40'hAA_AAAA_AAAA, 32'h5555_5555, 1,
                                answer(KIND_INSERT, 1'b0, 0, 32'd8)));
        // widest budget
        plan.push_back(plan_row(1, LEN_MAX, MODE_INSERT, 40'h55_5555_5555, 32'hAAAA_AAAA,
                                0, '0));
        plan.push_back(plan_row(0, '0, MODE_INSERT, 40'hAA_AAAA_AAAA, 32'h5555_5555, 0, '0));
        plan.push_back(plan_row(0, '0, MODE_INSERT, 40'd3, LEN_MAX, 0, '0));
        plan.push_back(plan_row(0, '0, MODE_LOOKUP, 40'd3, '0, 0, '0));
        // budget dropped below usage
        plan.push_back(plan_row(1, '0, MODE_INSERT, 40'd7, 32'd1, 1,
                                answer(KIND_INSERT, 1'b0, 0, LEN_MAX)));
        plan.push_back(plan_row(0, '0, MODE_INSERT, 40'd8, 32'd0, 0, '0));
        plan.push_back(plan_row(1, 32'd100, MODE_INSERT, 40'd9, 32'd50, 0, '0));
        plan.push_back(plan_row(0, '0, MODE_LOOKUP, KEY_MAX, '0, 0, '0));
        plan.push_back(plan_row(1, BUDGET_RESET, MODE_LOOKUP, 40'd8, '0, 0, '0));
        plan.push_back(plan_row(0, '0, MODE_INSERT, '0, '0, 0, '0));

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            row = plan[r];
            if (row.set_budget)
                write_budget(row.budget);
            send_access(row.mode, row.key, row.length);
            if (row.typed)
            begin
                void'(words_due.pop_back());
                words_due.push_back(row.want);
            end
            maybe_pause();
        end

        items_random = 0;
        phases_run = 0;
        while (items_random < RANDOM_ITEMS)
        begin
            quiet = (RANDOM_ITEMS - items_random <= QUIET_ITEMS);
            ph = (phases_run == 0) ? PH_FILL : phase_t'($urandom_range(0, 4));
            if (!quiet)
            begin
                case (ph)
                    PH_FILL:   write_budget($urandom_range(0, 1) ? LEN_MAX : BUDGET_RESET);
                    PH_TIGHT:  write_budget(LEN_W'($urandom_range(1, 5000)));
                    PH_WIDE:   write_budget(LEN_W'($urandom));
                    PH_SHRINK:
                        write_budget((bytes_held == 0) ? '0 :
                                     LEN_W'($urandom_range(0, bytes_held - 1)));
                    default:   wait_drained();
                endcase
            end
            insert_pct = (ph == PH_FILL) ? 85 : 55;
            burst = (ph == PH_FILL) ? $urandom_range(36, 44) : $urandom_range(10, 30);
            for (n = 0; n < burst && items_random < RANDOM_ITEMS; n++)
            begin
                quiet = (RANDOM_ITEMS - items_random <= QUIET_ITEMS);
                if ($urandom_range(0, 99) < insert_pct)
                begin
                    mode = MODE_INSERT;
                    if (recent_keys.size() > 0 && $urandom_range(0, 9) == 0)
                        key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                    else
                        key = random_key();
                    recent_keys.push_back(key);
                    if (recent_keys.size() > 64)
                        void'(recent_keys.pop_front());
                    length = pick_length(ph);
                end
                else
                begin
                    mode = MODE_LOOKUP;
                    if (recent_keys.size() > 0 && $urandom_range(0, 9) < 7)
                        key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                    else
                        key = random_key();
                    length = LEN_W'($urandom);
                end
                send_access(mode, key, length);
                items_random++;
                maybe_pause();
            end
            phases_run++;
        end

        wait_drained();
        repeat (10)
            @(posedge clk);
        word_errors += words_due.size();

        $display("%0d lookups and %0d inserts over %0d budget settings, %0d words checked",
                 lookups_sent, inserts_sent, budget_writes, words_seen);
        $display("%0d lookup hits, %0d refused inserts, %0d evictions, %0d inserts into a full table",
                 hits_seen, refusals_seen, evictions_seen, full_table_inserts);
        if (word_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
design/bblru_pkg.sv
design/bblru_req_if.sv
design/bblru_rsp_if.sv
design/bblru_ctrl.sv
design/bblru_dp.sv
design/byte_budget_lru_cache.sv
bench/tb_top.sv
